// ===== rtl/hse_pkg.sv =====
// Shared constants, payload types and state encodings of the heap sort engine.
package hse_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int DATA_W   = 32;
    localparam int LOADED_W = 11;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic signed [DATA_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0]  sorted_value;
        t_status                   status;
        logic                      last;
        logic [LOADED_W-1:0]       loaded_count;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_mem_req;

    typedef enum logic [2:0] {
        SS_IDLE,
        SS_B_RD,
        SS_B_LD,
        SS_RD,
        SS_CMP,
        SS_X_RD,
        SS_X_SWAP,
        SS_NEXT
    } t_sort_state;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_SORT,
        TS_FETCH,
        TS_FETCH_OUT
    } t_top_state;

endpackage

// ===== rtl/hse_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/hse_sorter.sv =====
// Heapsort sequencer: builds a max-heap in the element RAM, then extracts it in place.
module hse_sorter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hse_pkg::CNT_W-1:0] i_count,
    input  logic [hse_pkg::DATA_W-1:0] i_rd_a,
    input  logic [hse_pkg::DATA_W-1:0] i_rd_b,
    output hse_pkg::t_mem_req         o_mem,
    output logic                      o_done
);
    import hse_pkg::*;

    t_sort_state              r_state, n_state;
    logic                     r_extract, n_extract;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [CNT_W-1:0]         r_k, n_k;
    logic [ADDR_W-1:0]        r_node, n_node;
    logic [CNT_W-1:0]         r_size, n_size;
    logic signed [DATA_W-1:0] r_v, n_v;
    logic                     r_done, n_done;

    logic [CHILD_W-1:0]       lc, rc, size_ext;
    logic [CNT_W-1:0]         k_dec, n_dec;
    logic signed [DATA_W-1:0] rd_a_s, rd_b_s, big_val;
    logic                     left_bigger, take_right, rc_ok;

    // The sift carries the moving value in r_v and leaves a hole at r_node;
    // the value is written only where the sift stops.
    assign lc          = (CHILD_W'(r_node) << 1) + CHILD_W'(1);
    assign rc          = lc + CHILD_W'(1);
    assign size_ext    = CHILD_W'(r_size);
    assign rc_ok       = rc < size_ext;
    assign k_dec       = r_k - CNT_W'(1);
    assign n_dec       = r_n - CNT_W'(1);
    assign rd_a_s      = $signed(i_rd_a);
    assign rd_b_s      = $signed(i_rd_b);
    assign left_bigger = rd_a_s > r_v;
    assign big_val     = left_bigger ? rd_a_s : r_v;
    assign take_right  = rc_ok && (rd_b_s > big_val);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SS_IDLE: begin
                if (i_start && (i_count >= CNT_W'(2))) begin
                    n_state = SS_B_RD;
                end
            end
            SS_B_RD:   n_state = SS_B_LD;
            SS_B_LD:   n_state = SS_RD;
            SS_RD: begin
                if (lc >= size_ext) begin
                    n_state = SS_NEXT;
                end else begin
                    n_state = SS_CMP;
                end
            end
            SS_CMP: begin
                if (take_right || left_bigger) begin
                    n_state = SS_RD;
                end else begin
                    n_state = SS_NEXT;
                end
            end
            SS_X_RD:   n_state = SS_X_SWAP;
            SS_X_SWAP: n_state = SS_RD;
            SS_NEXT: begin
                if (k_dec != '0) begin
                    n_state = r_extract ? SS_X_RD : SS_B_RD;
                end else if (!r_extract) begin
                    n_state = SS_X_RD;
                end else begin
                    n_state = SS_IDLE;
                end
            end
            default:   n_state = SS_IDLE;
        endcase
    end

    always_comb begin
        n_extract     = r_extract;
        n_n           = r_n;
        n_k           = r_k;
        n_node        = r_node;
        n_size        = r_size;
        n_v           = r_v;
        n_done        = 1'b0;
        o_mem.we      = 1'b0;
        o_mem.waddr   = r_node;
        o_mem.wdata   = r_v;
        o_mem.raddr_a = lc[ADDR_W-1:0];
        o_mem.raddr_b = rc[ADDR_W-1:0];
        unique case (r_state)
            SS_IDLE: begin
                if (i_start) begin
                    n_n       = i_count;
                    n_k       = i_count >> 1;
                    n_extract = 1'b0;
                    n_done    = i_count < CNT_W'(2);
                end
            end
            SS_B_RD: begin
                o_mem.raddr_a = k_dec[ADDR_W-1:0];
            end
            SS_B_LD: begin
                n_v    = rd_a_s;
                n_node = k_dec[ADDR_W-1:0];
                n_size = r_n;
            end
            SS_RD: begin
                if (lc >= size_ext) begin
                    o_mem.we = 1'b1;
                end
            end
            SS_CMP: begin
                o_mem.we = 1'b1;
                if (take_right) begin
                    o_mem.wdata = rd_b_s;
                    n_node      = rc[ADDR_W-1:0];
                end else if (left_bigger) begin
                    o_mem.wdata = rd_a_s;
                    n_node      = lc[ADDR_W-1:0];
                end
            end
            SS_X_RD: begin
                o_mem.raddr_a = '0;
                o_mem.raddr_b = r_k[ADDR_W-1:0];
            end
            SS_X_SWAP: begin
                // The old root goes to the last heap slot; the old last value sifts from the root.
                o_mem.we    = 1'b1;
                o_mem.waddr = r_k[ADDR_W-1:0];
                o_mem.wdata = rd_a_s;
                n_v         = rd_b_s;
                n_node      = '0;
                n_size      = r_k;
            end
            SS_NEXT: begin
                if (k_dec != '0) begin
                    n_k = k_dec;
                end else if (!r_extract) begin
                    n_extract = 1'b1;
                    n_k       = n_dec;
                end else begin
                    n_done = 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_extract <= n_extract;
        r_n       <= n_n;
        r_k       <= n_k;
        r_node    <= n_node;
        r_size    <= n_size;
        r_v       <= n_v;
    end

    assign o_done = r_done;

endmodule

// ===== rtl/heap_sort_engine.sv =====
// Top level of the heap sort engine: command handling, set bookkeeping and RAM arbitration.
//
// Usage: drive i_cmd and raise start; the command transfers at a rising edge with start
// high and busy low. Every command gives exactly one result on o_result, marked by o_valid
// for one cycle; the receiver cannot hold results off.
// A load (op 0) writes the value into the element RAM; its result appears in the cycle after
// the transfer and busy stays low, so loads can transfer every cycle. A load into a full
// store is dropped with status 1. A load after any fetch starts a new set.
// A fetch (op 1) returns the next value in ascending order, with last set on the final one,
// or status 2 when nothing is left; on the first fetch of a set it first runs the in-place
// sort. The sort runs out of the element RAM, which reads both children of a node per
// cycle: each sift level passes through a read state and a compare state.
// busy is high for the whole fetch.
// Reset empties the set; the RAM contents are not cleared and need no clearing pass.
module heap_sort_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  hse_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_valid,
    output hse_pkg::t_result o_result
);
    import hse_pkg::*;

    t_top_state       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_fetch, n_fetch;
    logic             r_sorted, n_sorted;
    logic             r_valid, n_valid;
    t_result          r_out, n_out;

    t_mem_req          own_req, sort_req, mem_req;
    logic              sort_start, sort_done;
    logic [DATA_W-1:0] rd_a, rd_b;
    logic              accept;
    logic [CNT_W-1:0]  eff_count, fetch_inc;

    assign accept    = start && (r_state == TS_IDLE);
    assign eff_count = r_sorted ? '0 : r_count;
    assign fetch_inc = r_fetch + CNT_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: begin
                if (accept && (i_cmd.op == OP_FETCH)) begin
                    n_state = r_sorted ? TS_FETCH : TS_SORT;
                end
            end
            TS_SORT: begin
                if (sort_done) begin
                    n_state = TS_FETCH;
                end
            end
            TS_FETCH: begin
                n_state = (r_fetch >= r_count) ? TS_IDLE : TS_FETCH_OUT;
            end
            TS_FETCH_OUT: n_state = TS_IDLE;
            default:      n_state = TS_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_fetch    = r_fetch;
        n_sorted   = r_sorted;
        n_valid    = 1'b0;
        n_out      = r_out;
        sort_start = 1'b0;
        own_req.we      = 1'b0;
        own_req.waddr   = eff_count[ADDR_W-1:0];
        own_req.wdata   = i_cmd.value;
        own_req.raddr_a = r_fetch[ADDR_W-1:0];
        own_req.raddr_b = r_fetch[ADDR_W-1:0];
        unique case (r_state)
            TS_IDLE: begin
                if (accept) begin
                    if (i_cmd.op == OP_LOAD) begin
                        n_valid            = 1'b1;
                        n_out.sorted_value = '0;
                        n_out.last         = 1'b0;
                        n_sorted           = 1'b0;
                        n_fetch            = r_sorted ? '0 : r_fetch;
                        if (eff_count >= CNT_W'(CAPACITY)) begin
                            n_out.status       = ST_FULL;
                            n_out.loaded_count = LOADED_W'(eff_count);
                        end else begin
                            own_req.we         = 1'b1;
                            n_count            = eff_count + CNT_W'(1);
                            n_out.status       = ST_OK;
                            n_out.loaded_count = LOADED_W'(eff_count + CNT_W'(1));
                        end
                    end else if (!r_sorted) begin
                        n_sorted   = 1'b1;
                        n_fetch    = '0;
                        sort_start = 1'b1;
                    end
                end
            end
            TS_SORT: begin
                n_valid = 1'b0;
            end
            TS_FETCH: begin
                if (r_fetch >= r_count) begin
                    n_valid            = 1'b1;
                    n_out.sorted_value = '0;
                    n_out.status       = ST_EMPTY;
                    n_out.last         = 1'b0;
                    n_out.loaded_count = LOADED_W'(r_count);
                end
            end
            TS_FETCH_OUT: begin
                n_valid            = 1'b1;
                n_out.sorted_value = $signed(rd_a);
                n_out.status       = ST_OK;
                n_out.last         = fetch_inc == r_count;
                n_out.loaded_count = LOADED_W'(r_count);
                n_fetch            = fetch_inc;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    assign mem_req = (r_state == TS_SORT) ? sort_req : own_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= TS_IDLE;
            r_count  <= '0;
            r_fetch  <= '0;
            r_sorted <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_fetch  <= n_fetch;
            r_sorted <= n_sorted;
            r_valid  <= n_valid;
        end
        r_out <= n_out;
    end

    hse_sorter u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sort_start),
        .i_count (r_count),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b),
        .o_mem   (sort_req),
        .o_done  (sort_done)
    );

    hse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_req.we),
        .i_waddr   (mem_req.waddr),
        .i_wdata   (mem_req.wdata),
        .i_raddr_a (mem_req.raddr_a),
        .i_raddr_b (mem_req.raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign busy     = r_state != TS_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the heap sort engine: load/fetch commands against a heapsort predictor.
`timescale 1ns / 1ps

module testbench;

    import hse_pkg::*;

    typedef logic signed [DATA_W-1:0] t_elem;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          TAIL_CYCLES  = 16;
    localparam int          PRINT_LIMIT  = 50;
    localparam int          RANDOM_ITEMS = 30;
    localparam int          FULL_FETCHES = 4;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    heap_sort_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Shadow copy of the element set, sorted in place on the first fetch of a set.
    t_elem       held_values [CAPACITY];
    int unsigned held_count   = 0;
    int unsigned next_out     = 0;
    bit          set_sorted   = 1'b0;

    t_result     results_due [$];
    int          mismatch_count  = 0;
    int          sender_idle_pct = 0;
    int unsigned cycle_count     = 0;

    function automatic void sift_held_down(input int unsigned root, input int unsigned size);
        int unsigned node;
        int unsigned big;
        int unsigned lc;
        int unsigned rc;
        t_elem       tmp;
        bit          done;
        node = root;
        done = 1'b0;
        while (!done) begin
            big = node;
            lc  = 2 * node + 1;
            rc  = 2 * node + 2;
            if (lc < size && held_values[lc] > held_values[big]) big = lc;
            if (rc < size && held_values[rc] > held_values[big]) big = rc;
            if (big == node) begin
                done = 1'b1;
            end else begin
                tmp               = held_values[node];
                held_values[node] = held_values[big];
                held_values[big]  = tmp;
                node              = big;
            end
        end
    endfunction

    function automatic void heapsort_held(input int unsigned n);
        int unsigned k;
        t_elem       tmp;
        if (n < 2) return;
        for (k = n / 2; k > 0; k--) sift_held_down(k - 1, n);
        for (k = n - 1; k > 0; k--) begin
            tmp            = held_values[0];
            held_values[0] = held_values[k];
            held_values[k] = tmp;
            sift_held_down(0, k);
        end
    endfunction

    function automatic t_result engine_step_result(input t_cmd cmd);
        t_result r;
        r        = '0;
        r.status = ST_OK;
        if (cmd.op == OP_LOAD) begin
            // A load after any fetch opens a new set.
            if (set_sorted) begin
                held_count = 0;
                next_out   = 0;
                set_sorted = 1'b0;
            end
            if (held_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                held_values[held_count] = cmd.value;
                held_count++;
            end
        end else begin
            if (!set_sorted) begin
                heapsort_held(held_count);
                set_sorted = 1'b1;
                next_out   = 0;
            end
            if (next_out >= held_count) begin
                r.status = ST_EMPTY;
            end else begin
                r.sorted_value = held_values[next_out];
                next_out++;
                r.last = (next_out == held_count);
            end
        end
        r.loaded_count = held_count[LOADED_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Predict on every accepted command transfer, then check any result present this cycle.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (start && !busy) results_due.push_back(engine_step_result(i_cmd));
            if (o_valid !== 1'b0) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no command outstanding");
                end else begin
                    want = results_due.pop_front();
                    if (o_valid !== 1'b1)
                        report_mismatch("result strobe is unknown");
                    if (o_result.sorted_value !== want.sorted_value)
                        report_mismatch($sformatf("sorted_value got %0d, want %0d",
                            o_result.sorted_value, want.sorted_value));
                    if (o_result.status !== want.status)
                        report_mismatch($sformatf("status got %0d, want %0d",
                            o_result.status, want.status));
                    if (o_result.last !== want.last)
                        report_mismatch($sformatf("last got %b, want %b",
                            o_result.last, want.last));
                    if (o_result.loaded_count !== want.loaded_count)
                        report_mismatch($sformatf("loaded_count got %0d, want %0d",
                            o_result.loaded_count, want.loaded_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, results_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Leaves start high after the transfer so back-to-back commands can transfer without a gap.
    task automatic send_cmd(input t_op op, input t_elem value);
        t_cmd cmd;
        cmd.op    = op;
        cmd.value = value;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_elem pick_value();
        int near_zero;
        near_zero = $urandom_range(16);
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return near_zero - 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic load_then_fetch(input int loads, input int fetches);
        int i;
        for (i = 0; i < loads; i++) send_cmd(OP_LOAD, pick_value());
        for (i = 0; i < fetches; i++) send_cmd(OP_FETCH, $urandom());
    endtask

    // Right after reset nothing is loaded; the empty fetch still closes the set.
    task automatic test_fetch_on_empty_store();
        send_cmd(OP_FETCH, 32'sh0);
        send_cmd(OP_FETCH, -32'sd1);
        send_cmd(OP_LOAD, 32'sd5);
        send_cmd(OP_FETCH, 32'sh0);
        send_cmd(OP_FETCH, 32'sh0);
    endtask

    // Extremes and repeated values; ties must come out unchanged.
    task automatic test_field_extremes();
        send_cmd(OP_LOAD, 32'sh7FFF_FFFF);
        send_cmd(OP_LOAD, 32'sh8000_0000);
        send_cmd(OP_LOAD, 32'sh0);
        send_cmd(OP_LOAD, -32'sd1);
        send_cmd(OP_LOAD, 32'sh7FFF_FFFF);
        send_cmd(OP_LOAD, 32'shAAAA_AAAA);
        repeat (7) send_cmd(OP_FETCH, 32'sh5555_5555);
    endtask

    task automatic test_load_after_partial_fetch();
        send_cmd(OP_LOAD, 32'sd3);
        send_cmd(OP_LOAD, -32'sd2);
        send_cmd(OP_LOAD, 32'sd1);
        send_cmd(OP_FETCH, 32'sh0);
        send_cmd(OP_LOAD, 32'sd7);
        send_cmd(OP_FETCH, 32'sh0);
        send_cmd(OP_FETCH, 32'sh0);
    endtask

    // Fill the store, overflow it twice, then sort it and take the smallest few values.
    task automatic test_full_store();
        load_then_fetch(CAPACITY, 0);
        send_cmd(OP_LOAD, 32'sh1234_5678);
        send_cmd(OP_LOAD, 32'sh8000_0000);
        load_then_fetch(0, FULL_FETCHES);
    endtask

    task automatic test_random_sets(input int item_budget);
        int sent;
        int kind;
        int n;
        int fetches;
        int i;
        sent = 0;
        while (sent < item_budget) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                // Complete set, sometimes fetched past its end.
                n = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
                fetches = n + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
                load_then_fetch(n, fetches);
            end else if (kind < 92) begin
                // Set abandoned part way; with no fetch at all the next loads append.
                n = $urandom_range(1, 24);
                fetches = $urandom_range(0, n - 1);
                load_then_fetch(n, fetches);
            end else begin
                n = 0;
                fetches = $urandom_range(1, 12);
                for (i = 0; i < fetches; i++)
                    send_cmd(t_op'($urandom_range(1)), pick_value());
            end
            sent += n + fetches;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 9;
        test_fetch_on_empty_store();
        test_field_extremes();
        test_load_after_partial_fetch();
        wait_all_results();
        test_full_store();
        wait_all_results();
        test_random_sets(RANDOM_ITEMS);
        wait_all_results();

        sender_idle_pct = 62;
        test_random_sets(RANDOM_ITEMS);
        wait_all_results();

        sender_idle_pct = 0;
        test_random_sets(RANDOM_ITEMS);
        wait_all_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
